// ===== rtl/oads_pkg.sv =====
// Shared types and constants of the obstacle-avoiding drive sequencer.
package oads_pkg;

    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_LEFT    = 3'd1,
        CMD_RIGHT   = 3'd2,
        CMD_FORWARD = 3'd3,
        CMD_REVERSE = 3'd4,
        CMD_STOP    = 3'd5,
        CMD_FASTER  = 3'd6,
        CMD_SLOWER  = 3'd7
    } t_cmd;

    typedef enum logic [2:0] {
        REG_DECISION_PERIOD = 3'd0,
        REG_PENDING_DELAY   = 3'd1,
        REG_OBSTACLE_FAR    = 3'd2,
        REG_OBSTACLE_NEAR   = 3'd3,
        REG_EDGE_THRESHOLD  = 3'd4,
        REG_SPEED_STEP      = 3'd5,
        REG_SPEED_FLOOR     = 3'd6,
        REG_SPEED_CEILING   = 3'd7
    } t_reg_idx;

    localparam int CFG_DATA_W = 12;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 24;

    localparam logic [6:0] SPEED_MAX    = 7'd100;
    localparam logic [6:0] SPEED_RESET  = 7'd20;
    localparam logic [6:0] SPEED_CRAWL  = 7'd1;

    localparam logic [7:0]  DEF_DECISION_PERIOD = 8'd20;
    localparam logic [11:0] DEF_PENDING_DELAY   = 12'd1500;
    localparam logic [9:0]  DEF_OBSTACLE_FAR    = 10'd90;
    localparam logic [9:0]  DEF_OBSTACLE_NEAR   = 10'd5;
    localparam logic [9:0]  DEF_EDGE_THRESHOLD  = 10'd50;
    localparam logic [6:0]  DEF_SPEED_STEP      = 7'd10;
    localparam logic [6:0]  DEF_SPEED_FLOOR     = 7'd30;
    localparam logic [6:0]  DEF_SPEED_CEILING   = 7'd80;

    typedef struct packed {
        logic       run;
        logic       fwd;
        logic [6:0] speed;
    } t_wheel;

    typedef struct packed {
        t_cmd        cur;
        t_cmd        pend;
        logic [11:0] delay;
        logic [7:0]  period;
        logic [6:0]  speed;
        t_wheel      left;
        t_wheel      right;
    } t_state;

    typedef struct packed {
        logic [7:0]  decision_period;
        logic [11:0] pending_delay;
        logic [9:0]  obstacle_far;
        logic [9:0]  obstacle_near;
        logic [9:0]  edge_threshold;
        logic [6:0]  speed_step;
        logic [6:0]  speed_floor;
        logic [6:0]  speed_ceiling;
    } t_cfg;

    typedef struct packed {
        logic       cmd_valid;
        t_cmd       cmd_value;
        logic [9:0] front_distance;
        logic [9:0] floor_distance;
        logic       right_blocked;
        logic       left_blocked;
    } t_item;

endpackage

// ===== rtl/oads_decide.sv =====
// Next-state logic for one tick: follow-up timing, command intake and the decision step.
module oads_decide
    import oads_pkg::*;
(
    input  t_state i_state,
    input  t_cfg   i_cfg,
    input  t_item  i_item,
    output t_state o_state,
    output logic   o_decided
);

    always_comb begin
        t_state     s;
        logic [8:0] per_sum;
        logic [7:0] spd_sum;
        logic       obstacle;
        logic       dec;

        s        = i_state;
        dec      = 1'b0;
        spd_sum  = {1'b0, i_state.speed} + {1'b0, i_cfg.speed_step};
        obstacle = 1'b0;

        // A pending follow-up either counts its delay or takes over the command.
        if (s.pend != CMD_NONE) begin
            if (s.delay >= i_cfg.pending_delay) begin
                s.cur   = s.pend;
                s.pend  = CMD_NONE;
                s.delay = '0;
            end else begin
                s.delay = s.delay + 12'd1;
            end
        end
        if (i_item.cmd_valid) begin
            s.cur = i_item.cmd_value;
        end

        per_sum = {1'b0, s.period} + 9'd1;
        if (per_sum >= {1'b0, i_cfg.decision_period}) begin
            s.period = '0;
            dec      = 1'b1;
        end else begin
            s.period = per_sum[7:0];
        end

        if (dec) begin
            obstacle = (i_item.front_distance < i_cfg.obstacle_far) &&
                       (i_item.front_distance > i_cfg.obstacle_near);
            if (s.cur != CMD_STOP && s.cur != CMD_NONE && s.pend == CMD_NONE) begin
                if (obstacle) begin
                    if (i_item.right_blocked && i_item.left_blocked) begin
                        s.cur = CMD_REVERSE;
                    end else if (i_item.right_blocked) begin
                        s.cur = CMD_RIGHT;
                    end else begin
                        s.cur = CMD_LEFT;
                    end
                    s.pend = CMD_FORWARD;
                end else if (i_item.right_blocked && i_item.left_blocked) begin
                    s.cur  = CMD_REVERSE;
                    s.pend = CMD_RIGHT;
                end else if (i_item.right_blocked) begin
                    s.cur  = CMD_RIGHT;
                    s.pend = CMD_FORWARD;
                end else if (i_item.left_blocked) begin
                    s.cur  = CMD_LEFT;
                    s.pend = CMD_FORWARD;
                end
            end

            // Table edge: stop, though the dispatch below may restart the wheels.
            if (i_item.floor_distance > i_cfg.edge_threshold) begin
                s.left.run  = 1'b0;
                s.right.run = 1'b0;
                s.pend      = CMD_NONE;
            end

            case (s.cur)
                CMD_LEFT: begin
                    s.left  = '{run: 1'b1, fwd: 1'b1, speed: SPEED_CRAWL};
                    s.right = '{run: 1'b1, fwd: 1'b1, speed: s.speed};
                end
                CMD_RIGHT: begin
                    s.left  = '{run: 1'b1, fwd: 1'b1, speed: s.speed};
                    s.right = '{run: 1'b1, fwd: 1'b1, speed: SPEED_CRAWL};
                end
                CMD_FORWARD: begin
                    s.left  = '{run: 1'b1, fwd: 1'b1, speed: s.speed};
                    s.right = '{run: 1'b1, fwd: 1'b1, speed: s.speed};
                end
                CMD_REVERSE: begin
                    s.left  = '{run: 1'b1, fwd: 1'b0, speed: s.speed};
                    s.right = '{run: 1'b1, fwd: 1'b0, speed: s.speed};
                end
                CMD_STOP: begin
                    s.left.run  = 1'b0;
                    s.right.run = 1'b0;
                    s.pend      = CMD_NONE;
                end
                CMD_FASTER: begin
                    if (s.speed < i_cfg.speed_ceiling) begin
                        s.speed = (spd_sum > {1'b0, SPEED_MAX}) ? SPEED_MAX : spd_sum[6:0];
                        s.left.run    = 1'b1;
                        s.left.speed  = s.speed;
                        s.right.run   = 1'b1;
                        s.right.speed = s.speed;
                    end
                end
                CMD_SLOWER: begin
                    if (s.speed > i_cfg.speed_floor) begin
                        s.speed = (s.speed > i_cfg.speed_step) ?
                                  s.speed - i_cfg.speed_step : 7'd0;
                        s.left.run    = 1'b1;
                        s.left.speed  = s.speed;
                        s.right.run   = 1'b1;
                        s.right.speed = s.speed;
                    end
                end
                default: begin
                end
            endcase
        end

        o_state   = s;
        o_decided = dec;
    end

endmodule

// ===== rtl/obstacle_avoid_drive_sequencer.sv =====
// Top level of the obstacle-avoiding drive sequencer.
//
// Each slave transfer is one millisecond tick: tuser carries the command-valid
// flag, tdata the command, the front and floor distances and the side sensor
// bits. Each tick gives exactly one master transfer with both wheel settings,
// the active command and a flag telling whether a decision step ran.
// The user writes the configuration registers (plain write port: enable,
// index, data) only while no tick is in flight; the block does not enforce it.
//
// The result of a tick is in the output register from the clock edge that
// takes its transfer. One tick is accepted every cycle while the receiver
// keeps up; the state update is a single pass of compare-and-select logic
// from the drive state registers to the output register.
// When the receiver stalls, the result is held and the next tick is still
// taken in the cycle the held result leaves, so s_axis_tready follows
// m_axis_tready whenever a result is waiting.
// Reset (synchronous, active low) clears the output, loads the default
// configuration, sets the speed to twenty and stops both wheels.
module obstacle_avoid_drive_sequencer
    import oads_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [2:0] cmd_value, [12:3] front_distance, [22:13] floor_distance,
    // [23] right_blocked, [24] left_blocked, [31:25] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [0] cmd_valid
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] left_run, [1] left_forward, [8:2] left_speed, [9] right_run,
    // [10] right_forward, [17:11] right_speed, [20:18] active_cmd,
    // [21] decided, [23:22] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg                  r_cfg;
    t_state                r_state;
    t_state                n_state;
    logic                  n_decided;
    t_item                 w_item;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  w_in_fire;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign w_item.cmd_valid      = s_axis_tuser;
    assign w_item.cmd_value      = t_cmd'(s_axis_tdata[2:0]);
    assign w_item.front_distance = s_axis_tdata[12:3];
    assign w_item.floor_distance = s_axis_tdata[22:13];
    assign w_item.right_blocked  = s_axis_tdata[23];
    assign w_item.left_blocked   = s_axis_tdata[24];

    oads_decide u_decide (
        .i_state   (r_state),
        .i_cfg     (r_cfg),
        .i_item    (w_item),
        .o_state   (n_state),
        .o_decided (n_decided)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.decision_period <= DEF_DECISION_PERIOD;
            r_cfg.pending_delay   <= DEF_PENDING_DELAY;
            r_cfg.obstacle_far    <= DEF_OBSTACLE_FAR;
            r_cfg.obstacle_near   <= DEF_OBSTACLE_NEAR;
            r_cfg.edge_threshold  <= DEF_EDGE_THRESHOLD;
            r_cfg.speed_step      <= DEF_SPEED_STEP;
            r_cfg.speed_floor     <= DEF_SPEED_FLOOR;
            r_cfg.speed_ceiling   <= DEF_SPEED_CEILING;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_addr))
                REG_DECISION_PERIOD: r_cfg.decision_period <= i_cfg_wdata[7:0];
                REG_PENDING_DELAY:   r_cfg.pending_delay   <= i_cfg_wdata[11:0];
                REG_OBSTACLE_FAR:    r_cfg.obstacle_far    <= i_cfg_wdata[9:0];
                REG_OBSTACLE_NEAR:   r_cfg.obstacle_near   <= i_cfg_wdata[9:0];
                REG_EDGE_THRESHOLD:  r_cfg.edge_threshold  <= i_cfg_wdata[9:0];
                REG_SPEED_STEP:      r_cfg.speed_step      <= i_cfg_wdata[6:0];
                REG_SPEED_FLOOR:     r_cfg.speed_floor     <= i_cfg_wdata[6:0];
                REG_SPEED_CEILING:   r_cfg.speed_ceiling   <= i_cfg_wdata[6:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.cur    <= CMD_NONE;
            r_state.pend   <= CMD_NONE;
            r_state.delay  <= '0;
            r_state.period <= '0;
            r_state.speed  <= SPEED_RESET;
            r_state.left   <= '{run: 1'b0, fwd: 1'b1, speed: 7'd0};
            r_state.right  <= '{run: 1'b0, fwd: 1'b1, speed: 7'd0};
            r_out_valid    <= 1'b0;
        end else begin
            if (w_in_fire) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_out_data <= {2'b00, n_decided, n_state.cur,
                           n_state.right.speed, n_state.right.fwd, n_state.right.run,
                           n_state.left.speed, n_state.left.fwd, n_state.left.run};
        end
    end

    a_speed_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.speed <= SPEED_MAX)
        else $error("drive speed above its limit");

    a_decision_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire && n_decided |=> r_state.period == 8'd0)
        else $error("period counter not restarted after a decision step");

    a_stop_clears_followup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire && n_decided && n_state.cur == CMD_STOP |=> r_state.pend == CMD_NONE)
        else $error("follow-up command survived a stop decision");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> s_axis_tready)
        else $error("input stalled while the output register is empty");

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the obstacle-avoiding drive sequencer.
module testbench;
    import oads_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LONG_HOLD = 300;

    typedef struct {
        logic       left_run;
        logic       left_fwd;
        logic [6:0] left_speed;
        logic       right_run;
        logic       right_fwd;
        logic [6:0] right_speed;
        t_cmd       active;
        logic       decided;
    } t_drive_report;

    // Tracks the drive state of the car and the wheel reports still owed by the block.
    class t_drive_scoreboard;
        t_cfg          cfg;
        t_cmd          cur_cmd;
        t_cmd          follow_cmd;
        logic [11:0]   follow_wait;
        int            period_ticks;
        int            drive_speed;
        t_wheel        lw;
        t_wheel        rw;
        t_drive_report owed_reports[$];
        int            errors;

        function new();
            cfg.decision_period = DEF_DECISION_PERIOD;
            cfg.pending_delay   = DEF_PENDING_DELAY;
            cfg.obstacle_far    = DEF_OBSTACLE_FAR;
            cfg.obstacle_near   = DEF_OBSTACLE_NEAR;
            cfg.edge_threshold  = DEF_EDGE_THRESHOLD;
            cfg.speed_step      = DEF_SPEED_STEP;
            cfg.speed_floor     = DEF_SPEED_FLOOR;
            cfg.speed_ceiling   = DEF_SPEED_CEILING;
            cur_cmd      = CMD_NONE;
            follow_cmd   = CMD_NONE;
            follow_wait  = '0;
            period_ticks = 0;
            drive_speed  = 20;
            lw           = '{run: 1'b0, fwd: 1'b1, speed: 7'd0};
            rw           = '{run: 1'b0, fwd: 1'b1, speed: 7'd0};
            errors       = 0;
        endfunction

        function t_wheel spin(t_wheel w, int s);
            t_wheel n;
            n       = w;
            n.speed = s[6:0];
            n.run   = 1'b1;
            return n;
        endfunction

        function void steer(t_item it);
            logic rb;
            logic lb;
            rb = it.right_blocked;
            lb = it.left_blocked;
            if (cur_cmd != CMD_STOP && cur_cmd != CMD_NONE && follow_cmd == CMD_NONE) begin
                if (it.front_distance < cfg.obstacle_far &&
                        it.front_distance > cfg.obstacle_near) begin
                    if (rb && lb) begin
                        cur_cmd = CMD_REVERSE;
                    end else if (rb) begin
                        cur_cmd = CMD_RIGHT;
                    end else begin
                        cur_cmd = CMD_LEFT;
                    end
                    follow_cmd = CMD_FORWARD;
                end else if (rb && lb) begin
                    cur_cmd    = CMD_REVERSE;
                    follow_cmd = CMD_RIGHT;
                end else if (rb) begin
                    cur_cmd    = CMD_RIGHT;
                    follow_cmd = CMD_FORWARD;
                end else if (lb) begin
                    cur_cmd    = CMD_LEFT;
                    follow_cmd = CMD_FORWARD;
                end
            end
            // A table edge stops the wheels, but the command below may restart them.
            if (it.floor_distance > cfg.edge_threshold) begin
                lw.run     = 1'b0;
                rw.run     = 1'b0;
                follow_cmd = CMD_NONE;
            end
            case (cur_cmd)
                CMD_LEFT: begin
                    lw.fwd = 1'b1;
                    rw.fwd = 1'b1;
                    lw     = spin(lw, 1);
                    rw     = spin(rw, drive_speed);
                end
                CMD_RIGHT: begin
                    lw.fwd = 1'b1;
                    rw.fwd = 1'b1;
                    lw     = spin(lw, drive_speed);
                    rw     = spin(rw, 1);
                end
                CMD_FORWARD, CMD_REVERSE: begin
                    lw.fwd = (cur_cmd == CMD_FORWARD);
                    rw.fwd = (cur_cmd == CMD_FORWARD);
                    lw     = spin(lw, drive_speed);
                    rw     = spin(rw, drive_speed);
                end
                CMD_STOP: begin
                    lw.run     = 1'b0;
                    rw.run     = 1'b0;
                    follow_cmd = CMD_NONE;
                end
                CMD_FASTER: begin
                    if (drive_speed < cfg.speed_ceiling) begin
                        drive_speed = drive_speed + cfg.speed_step;
                        if (drive_speed > 100) begin
                            drive_speed = 100;
                        end
                        lw = spin(lw, drive_speed);
                        rw = spin(rw, drive_speed);
                    end
                end
                CMD_SLOWER: begin
                    if (drive_speed > cfg.speed_floor) begin
                        if (drive_speed > cfg.speed_step) begin
                            drive_speed = drive_speed - cfg.speed_step;
                        end else begin
                            drive_speed = 0;
                        end
                        lw = spin(lw, drive_speed);
                        rw = spin(rw, drive_speed);
                    end
                end
                default: begin
                end
            endcase
        endfunction

        function void note_tick(t_item it);
            t_drive_report r;
            if (follow_cmd != CMD_NONE) begin
                if (follow_wait >= cfg.pending_delay) begin
                    cur_cmd     = follow_cmd;
                    follow_cmd  = CMD_NONE;
                    follow_wait = '0;
                end else begin
                    follow_wait = follow_wait + 12'd1;
                end
            end
            if (it.cmd_valid) begin
                cur_cmd = it.cmd_value;
            end
            r.decided    = 1'b0;
            period_ticks = period_ticks + 1;
            if (period_ticks >= cfg.decision_period) begin
                period_ticks = 0;
                r.decided    = 1'b1;
                steer(it);
            end
            r.left_run    = lw.run;
            r.left_fwd    = lw.fwd;
            r.left_speed  = lw.speed;
            r.right_run   = rw.run;
            r.right_fwd   = rw.fwd;
            r.right_speed = rw.speed;
            r.active      = cur_cmd;
            owed_reports.push_back(r);
        endfunction

        function void compare(string name, logic [6:0] want, logic [6:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_report(logic [OUT_DATA_W-1:0] d);
            t_drive_report want;
            if (owed_reports.size() == 0) begin
                $error("result 0x%h arrived with no tick outstanding", d);
                errors++;
                return;
            end
            want = owed_reports.pop_front();
            compare("left_run", 7'(want.left_run), 7'(d[0]));
            compare("left_forward", 7'(want.left_fwd), 7'(d[1]));
            compare("left_speed", want.left_speed, d[8:2]);
            compare("right_run", 7'(want.right_run), 7'(d[9]));
            compare("right_forward", 7'(want.right_fwd), 7'(d[10]));
            compare("right_speed", want.right_speed, d[17:11]);
            compare("active_cmd", 7'(want.active), 7'(d[20:18]));
            compare("decided", 7'(want.decided), 7'(d[21]));
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_we = 1'b0;
    logic [2:0]            i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    t_drive_scoreboard sb = new();
    bit                no_idle = 1'b0;
    bit                hold_req = 1'b0;

    obstacle_avoid_drive_sequencer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Offers one tick, waits for its transfer, then idles for a random gap.
    task automatic send_tick(t_item it);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.cmd_valid;
        s_axis_tdata  <= {7'd0, it.left_blocked, it.right_blocked, it.floor_distance,
                          it.front_distance, it.cmd_value};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_tick(it);
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drive_tick(int v, t_cmd c, int front, int floor_d, int rb, int lb);
        t_item it;
        it.cmd_valid      = 1'(v);
        it.cmd_value      = c;
        it.front_distance = 10'(front);
        it.floor_distance = 10'(floor_d);
        it.right_blocked  = 1'(rb);
        it.left_blocked   = 1'(lb);
        send_tick(it);
    endtask

    function automatic t_item random_tick();
        t_item it;
        int    r;
        it.cmd_valid = ($urandom_range(0, 4) == 0);
        it.cmd_value = t_cmd'($urandom_range(0, 7));
        r = $urandom_range(0, 9);
        if (r < 4 && sb.cfg.obstacle_near < sb.cfg.obstacle_far) begin
            it.front_distance = 10'($urandom_range(sb.cfg.obstacle_near,
                                                   sb.cfg.obstacle_far));
        end else if (r < 6) begin
            case ($urandom_range(0, 3))
                0: it.front_distance = '0;
                1: it.front_distance = '1;
                2: it.front_distance = sb.cfg.obstacle_far;
                default: it.front_distance = sb.cfg.obstacle_near;
            endcase
        end else begin
            it.front_distance = 10'($urandom_range(0, 1023));
        end
        if ($urandom_range(0, 9) < 8) begin
            it.floor_distance = 10'($urandom_range(0, sb.cfg.edge_threshold));
        end else begin
            it.floor_distance = 10'($urandom_range(sb.cfg.edge_threshold, 1023));
        end
        it.right_blocked = ($urandom_range(0, 9) < 3);
        it.left_blocked  = ($urandom_range(0, 9) < 3);
        return it;
    endfunction

    task automatic random_ticks(int count);
        repeat (count) send_tick(random_tick());
    endtask

    // Waits until every owed report has been collected, with the input idle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.owed_reports.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [CFG_DATA_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= v;
        @(posedge i_clk);
    endtask

    task automatic load_config(t_cfg c);
        drain();
        write_reg(REG_DECISION_PERIOD, CFG_DATA_W'(c.decision_period));
        write_reg(REG_PENDING_DELAY, CFG_DATA_W'(c.pending_delay));
        write_reg(REG_OBSTACLE_FAR, CFG_DATA_W'(c.obstacle_far));
        write_reg(REG_OBSTACLE_NEAR, CFG_DATA_W'(c.obstacle_near));
        write_reg(REG_EDGE_THRESHOLD, CFG_DATA_W'(c.edge_threshold));
        write_reg(REG_SPEED_STEP, CFG_DATA_W'(c.speed_step));
        write_reg(REG_SPEED_FLOOR, CFG_DATA_W'(c.speed_floor));
        write_reg(REG_SPEED_CEILING, CFG_DATA_W'(c.speed_ceiling));
        i_cfg_we <= 1'b0;
        sb.cfg = c;
        @(posedge i_clk);
    endtask

    function automatic t_cfg make_cfg(int period, int delay, int far_cm, int near_cm,
                                      int edge_cm, int step, int floor_spd, int ceil_spd);
        t_cfg c;
        c.decision_period = 8'(period);
        c.pending_delay   = 12'(delay);
        c.obstacle_far    = 10'(far_cm);
        c.obstacle_near   = 10'(near_cm);
        c.edge_threshold  = 10'(edge_cm);
        c.speed_step      = 7'(step);
        c.speed_floor     = 7'(floor_spd);
        c.speed_ceiling   = 7'(ceil_spd);
        return c;
    endfunction

    // Receiver: accepts results in random bursts, with one long hold-off on request.
    initial begin
        int hold_left;
        int run_left;
        hold_left = 0;
        run_left  = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_left == 0 && run_left == 0) begin
                if (hold_req) begin
                    hold_req  = 1'b0;
                    hold_left = LONG_HOLD;
                end else begin
                    hold_left = pick_gap();
                    run_left  = $urandom_range(1, 12);
                end
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                m_axis_tready <= 1'b1;
                run_left--;
            end
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_report(m_axis_tdata);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset configuration.
        random_ticks(60);

        // Directed: a decision on every tick and a short follow-up delay.
        load_config(make_cfg(1, 2, 90, 5, 50, 30, 20, 90));
        drive_tick(1, CMD_FORWARD, 1023, 0, 0, 0);
        drive_tick(1, CMD_NONE, 1023, 0, 0, 0);
        drive_tick(1, CMD_FORWARD, 50, 0, 0, 0);
        drive_tick(0, CMD_NONE, 1023, 0, 0, 0);
        drive_tick(0, CMD_NONE, 1023, 0, 0, 0);
        drive_tick(0, CMD_NONE, 1023, 0, 0, 0);
        drive_tick(0, CMD_NONE, 50, 0, 1, 0);
        drive_tick(1, CMD_FORWARD, 50, 0, 1, 1);
        drive_tick(1, CMD_STOP, 50, 0, 1, 1);
        drive_tick(1, CMD_REVERSE, 1023, 0, 1, 1);
        drive_tick(1, CMD_LEFT, 1023, 1023, 0, 0);
        drive_tick(1, CMD_RIGHT, 90, 0, 0, 1);
        drive_tick(1, CMD_STOP, 5, 0, 0, 0);
        drive_tick(1, CMD_FASTER, 1023, 0, 0, 0);
        drive_tick(0, CMD_SLOWER, 1023, 0, 0, 0);
        drive_tick(0, CMD_SLOWER, 1023, 0, 0, 0);
        drive_tick(1, CMD_SLOWER, 1023, 0, 0, 0);
        drive_tick(0, CMD_NONE, 1023, 0, 0, 0);
        drive_tick(0, CMD_NONE, 1023, 0, 0, 0);
        drive_tick(1, CMD_FORWARD, 6, 0, 0, 0);
        drive_tick(1, CMD_STOP, 1023, 51, 0, 0);
        drive_tick(1, CMD_FORWARD, 0, 50, 0, 0);
        drive_tick(1, CMD_FORWARD, 89, 0, 1, 1);

        // Widest thresholds, largest speed step.
        load_config(make_cfg(1, 1, 1023, 0, 1023, 100, 0, 100));
        random_ticks(250);

        // Slowest decisions and follow-ups, with no idling on either side.
        load_config(make_cfg(255, 4095, 0, 1023, 0, 1, 100, 0));
        no_idle = 1'b1;
        random_ticks(270);
        no_idle = 1'b0;

        // The receiver holds off for a long stretch while ticks keep coming.
        load_config(make_cfg(3, 20, 200, 20, 500, 7, 15, 95));
        hold_req = 1'b1;
        random_ticks(300);

        repeat (2) begin
            load_config(make_cfg($urandom_range(1, 8), $urandom_range(1, 60),
                                 $urandom_range(0, 1023), $urandom_range(0, 1023),
                                 $urandom_range(0, 1023), $urandom_range(1, 100),
                                 $urandom_range(0, 100), $urandom_range(0, 100)));
            random_ticks(200);
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
